/* design/nnis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_pkg: shared types and constants of the nearest-neighbor scaler
// Sizes of the pixel store, item formats between the front, back and result
// queue, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package nnis_pkg;

   // pixel store
   localparam int MAX_PIXELS = 4096;
   localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int LOAD_W     = $clog2(MAX_PIXELS + 1);

   // image geometry
   localparam int SIZE_W   = 13;
   localparam int POS_W    = 12;
   localparam int SIZE_MAX = 4096;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;

   // column * width stays below 2^24 for positions up to 4095 and sizes up to 4096
   localparam int QUO_W    = 24;
   localparam int QCNT_W   = $clog2(QUO_W + 1);
   localparam int IDX_W    = 2 * SIZE_W;

   // queues
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EMIT = 1'b1
   } kind_type;

   // item classified by the front
   typedef struct packed {
      kind_type         kind;
      logic [PIX_W-1:0] pixel;
   } cmd_type;

   // result item
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } rsp_type;

   // size registers as written
   typedef struct packed {
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [SIZE_W-1:0] dst_width;
      logic [SIZE_W-1:0] dst_height;
   } cfg_type;

   // back sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_CLAMP,
      ST_INDEX,
      ST_READ,
      ST_PUSH
   } state_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(SIZE_MAX)) begin
         r = SIZE_W'(SIZE_MAX);
      end
      return r;
   endfunction

endpackage : nnis_pkg
`default_nettype wire

/* design/nearest_neighbor_image_scaler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler: nearest-neighbor RGB image scaler
// Stores a source image pixel by pixel and emits the scaled output raster.
// ----------------------------------------------------------------------------
// Push load items (opcode 0) to fill the pixel store in row-major order, then
// push one emit item (opcode 1) per output pixel; each emit returns the source
// pixel nearest to the next output position, with frame_last set on the final
// pixel, after which position and load address restart at zero. Loads are
// written straight from idle; an emit runs two 24-step iterative dividers for
// column and row, then clamp, index and store read. Input and result queues
// let the source keep pushing while a result waits. The user must write sizes
// through the csr port only while the block is idle; the block does not check.
module nearest_neighbor_image_scaler
   import nnis_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input items
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_opcode,
   input  wire logic [CHAN_W-1:0]     req_in_red,
   input  wire logic [CHAN_W-1:0]     req_in_green,
   input  wire logic [CHAN_W-1:0]     req_in_blue,
   // result items
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [CHAN_W-1:0]          rsp_out_red,
   output logic [CHAN_W-1:0]          rsp_out_green,
   output logic [CHAN_W-1:0]          rsp_out_blue,
   output logic                       rsp_frame_last,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_item;
   logic    rsp_room, rsp_push;
   rsp_type rsp_item, rsp_head;

   // size registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  cfg_in.src_width  = csr_wdata;
            CSR_SRC_HEIGHT: cfg_in.src_height = csr_wdata;
            CSR_DST_WIDTH:  cfg_in.dst_width  = csr_wdata;
            CSR_DST_HEIGHT: cfg_in.dst_height = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= SIZE_RESET;
         cfg_ff.src_height <= SIZE_RESET;
         cfg_ff.dst_width  <= SIZE_RESET;
         cfg_ff.dst_height <= SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept and classify
   nnis_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_opcode   (req_opcode),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .cmd_valid    (cmd_valid),
      .cmd_item     (cmd_item),
      .cmd_pop      (cmd_pop)
   );

   // execute loads and emits
   nnis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   // hold results for the consumer
   nnis_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_out_red    = rsp_head.pixel[PIX_W-1 -: CHAN_W];
   assign rsp_out_green  = rsp_head.pixel[2*CHAN_W-1 -: CHAN_W];
   assign rsp_out_blue   = rsp_head.pixel[CHAN_W-1:0];
   assign rsp_frame_last = rsp_head.last;

endmodule : nearest_neighbor_image_scaler
`default_nettype wire

/* design/nnis_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_front: input side of the scaler
// Accepts items, classifies them as load or emit and holds them in a short
// queue until the back takes them.
// ----------------------------------------------------------------------------
module nnis_front
   import nnis_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_opcode,
   input  wire logic [CHAN_W-1:0] req_in_red,
   input  wire logic [CHAN_W-1:0] req_in_green,
   input  wire logic [CHAN_W-1:0] req_in_blue,
   output logic                   cmd_valid,
   output cmd_type                cmd_item,
   input  wire logic              cmd_pop
);

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type           queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_ok;
   cmd_type           new_item;

   // classify the incoming item
   always_comb begin
      new_item.kind  = req_opcode ? KIND_EMIT : KIND_LOAD;
      new_item.pixel = {req_in_red, req_in_green, req_in_blue};
   end

   assign req_full  = (count_ff == CNT_W'(CMD_DEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = queue_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef SYNTHESIS
   // count never passes the queue depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CMD_DEPTH))
      else $error("front queue count overflow");
`endif

endmodule : nnis_front
`default_nettype wire

/* design/nnis_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle, for scaling an output
// position into a source coordinate.
// ----------------------------------------------------------------------------
module nnis_divider
   import nnis_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [QUO_W-1:0]  dividend,
   input  wire logic [SIZE_W-1:0] divisor,
   output logic                   busy,
   output logic [QUO_W-1:0]       quotient
);

   logic              busy_ff, busy_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;
   logic [SIZE_W:0]   trial;
   logic              fits;

   // one restoring step
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = QCNT_W'(QUO_W);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[QUO_W-2:0], fits};
         rem_in   = fits ? SIZE_W'(trial - {1'b0, dvs_ff}) : trial[SIZE_W-1:0];
         count_in = count_ff - 1'b1;
         busy_in  = (count_ff != QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule : nnis_divider
`default_nettype wire

/* design/nnis_rsp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_rsp_queue: result queue of the scaler
// Holds finished result items until the consumer pops them, so the back can
// go on with loads while a result waits.
// ----------------------------------------------------------------------------
module nnis_rsp_queue
   import nnis_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_push,
   input  wire rsp_type rsp_item,
   output logic         rsp_room,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_head
);

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_type          queue_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;

   assign rsp_empty = (count_ff == '0);
   assign rsp_room  = (count_ff != CNT_W'(RSP_DEPTH));
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_head  = queue_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (rsp_push && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!rsp_push && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         queue_ff[wr_ptr_ff] <= rsp_item;
      end
   end

endmodule : nnis_rsp_queue
`default_nettype wire

/* design/nnis_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_back: execution side of the scaler
// Writes loaded pixels into the pixel store, and for each emit scales the
// output position to a source pixel, reads it and hands the result on.
// ----------------------------------------------------------------------------
module nnis_back
   import nnis_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_item,
   output logic         cmd_pop,
   input  wire logic    rsp_room,
   output logic         rsp_push,
   output rsp_type      rsp_item
);

   state_type          state_ff, state_in;
   logic [LOAD_W-1:0]  load_addr_ff, load_addr_in;
   logic [POS_W-1:0]   col_ff, col_in;
   logic [POS_W-1:0]   row_ff, row_in;

   logic [QUO_W-1:0]   numx_ff, numy_ff;
   logic [POS_W-1:0]   sx_ff, sy_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [PIX_W-1:0]   rd_data_ff;
   logic               in_range_ff;

   logic [SIZE_W-1:0]  sw, sh, dw, dh;
   logic               mem_we, mem_re, div_start;
   logic               store_open, idx_ok;
   logic               bx_busy, by_busy;
   logic [QUO_W-1:0]   qx, qy;
   logic               col_end, row_end;
   logic [SIZE_W-1:0]  sx_max, sy_max;

   logic [PIX_W-1:0]   store_mem [MAX_PIXELS];

   // effective sizes
   assign sw = eff_size(cfg.src_width);
   assign sh = eff_size(cfg.src_height);
   assign dw = eff_size(cfg.dst_width);
   assign dh = eff_size(cfg.dst_height);

   assign store_open = (load_addr_ff < LOAD_W'(MAX_PIXELS));
   assign idx_ok     = (idx_ff < IDX_W'(MAX_PIXELS));
   assign col_end    = ({1'b0, col_ff} >= dw - 1'b1);
   assign row_end    = ({1'b0, row_ff} >= dh - 1'b1);
   assign sx_max     = sw - 1'b1;
   assign sy_max     = sh - 1'b1;

   // source column and row dividers
   nnis_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numx_ff),
      .divisor  (dw),
      .busy     (bx_busy),
      .quotient (qx)
   );

   nnis_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numy_ff),
      .divisor  (dh),
      .busy     (by_busy),
      .quotient (qy)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_item.kind == KIND_EMIT && rsp_room) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (!bx_busy && !by_busy) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: state_in = ST_INDEX;
         ST_INDEX: state_in = ST_READ;
         ST_READ:  state_in = ST_PUSH;
         ST_PUSH:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      div_start = 1'b0;
      rsp_push  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_item.kind == KIND_LOAD) begin
                  cmd_pop = 1'b1;
                  mem_we  = store_open;
               end else if (rsp_room) begin
                  cmd_pop = 1'b1;
               end
            end
         end
         ST_START: div_start = 1'b1;
         ST_READ:  mem_re    = idx_ok;
         ST_PUSH:  rsp_push  = 1'b1;
         default: begin
         end
      endcase
   end

   // position and load address
   always_comb begin
      load_addr_in = load_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (mem_we) begin
         load_addr_in = load_addr_ff + 1'b1;
      end
      if (rsp_push) begin
         if (col_end && row_end) begin
            col_in       = '0;
            row_in       = '0;
            load_addr_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_addr_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         load_addr_ff <= load_addr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   // datapath: scaled numerators, clamp, store index, read
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         numx_ff <= QUO_W'(col_ff) * QUO_W'(sw);
         numy_ff <= QUO_W'(row_ff) * QUO_W'(sh);
      end
      if (state_ff == ST_CLAMP) begin
         sx_ff <= (qx > QUO_W'(sx_max)) ? POS_W'(sx_max) : POS_W'(qx);
         sy_ff <= (qy > QUO_W'(sy_max)) ? POS_W'(sy_max) : POS_W'(qy);
      end
      if (state_ff == ST_INDEX) begin
         idx_ff <= IDX_W'(sy_ff) * IDX_W'(sw) + IDX_W'(sx_ff);
      end
      if (state_ff == ST_READ) begin
         in_range_ff <= idx_ok;
      end
   end

   // pixel store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[load_addr_ff[ADDR_W-1:0]] <= cmd_item.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   // result item
   assign rsp_item.pixel = in_range_ff ? rd_data_ff : '0;
   assign rsp_item.last  = col_end && row_end;

`ifndef SYNTHESIS
   // a result is only produced when the room reserved at emit start is there
   assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_room)
      else $error("result pushed into a full queue");

   // no store write past capacity
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (load_addr_ff < LOAD_W'(MAX_PIXELS)))
      else $error("store write beyond capacity");

   // the dividers are both done when leaving the divide wait
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP) |-> (!bx_busy && !by_busy && $past(state_ff == ST_DIV)))
      else $error("clamp entered with divider still running");

   // an item is only taken from the front when one waits
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("pop from empty front queue");
`endif

endmodule : nnis_back
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the nearest-neighbor image scaler
// Fills the pixel store with load items and walks the output raster with emit
// items. The size registers change between phases, among them zero, the
// 4096 limit and the all-ones value. A tracker keeps its own copy of the
// store and the raster position, works out each scaled pixel and checks every
// result item field by field. Both sides idle at random, and the result side
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb
   import nnis_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 40;
   localparam int unsigned SOURCE_CAP    = 64;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } out_pixel_type;

   // copy of the pixel store and raster position, with the pixels still due
   class raster_tracker;
      logic [PIX_W-1:0]  store [MAX_PIXELS];
      int unsigned       load_addr;
      int unsigned       column;
      int unsigned       row;
      logic [SIZE_W-1:0] sizes [4];
      out_pixel_type     pixels_due [$];
      int unsigned       mismatches;

      function new();
         load_addr  = 0;
         column     = 0;
         row        = 0;
         mismatches = 0;
         foreach (sizes[i]) sizes[i] = SIZE_RESET;
         foreach (store[i]) store[i] = '0;
      endfunction

      function void set_size(csr_index_type idx, logic [SIZE_W-1:0] value);
         sizes[int'(idx)] = value;
      endfunction

      // zero acts as one, anything above the limit acts as the limit
      function int unsigned size_of(csr_index_type idx);
         int unsigned v;
         v = sizes[int'(idx)];
         if (v == 0) begin
            v = 1;
         end else if (v > SIZE_MAX) begin
            v = SIZE_MAX;
         end
         return v;
      endfunction

      // apply one accepted item and queue the pixel it causes
      function void note_item(kind_type kind, logic [CHAN_W-1:0] red,
                              logic [CHAN_W-1:0] green, logic [CHAN_W-1:0] blue);
         int unsigned      sw, sh, dw, dh;
         int unsigned      sx, sy, idx;
         logic [PIX_W-1:0] pix;
         bit               col_end, row_end;
         if (kind == KIND_LOAD) begin
            // loads past the store capacity are dropped
            if (load_addr < MAX_PIXELS) begin
               store[load_addr] = {red, green, blue};
               load_addr++;
            end
            return;
         end
         sw = size_of(CSR_SRC_WIDTH);
         sh = size_of(CSR_SRC_HEIGHT);
         dw = size_of(CSR_DST_WIDTH);
         dh = size_of(CSR_DST_HEIGHT);
         // source coordinate saturates when the position lies past the frame
         sx = (column * sw) / dw;
         sy = (row * sh) / dh;
         if (sx > sw - 1) sx = sw - 1;
         if (sy > sh - 1) sy = sh - 1;
         idx = sy * sw + sx;
         pix = (idx < MAX_PIXELS) ? store[idx] : '0;
         col_end = (column >= dw - 1);
         row_end = (row >= dh - 1);
         pixels_due.push_back({pix, col_end && row_end});
         // advance the raster, restart position and load address after the frame
         if (col_end && row_end) begin
            column    = 0;
            row       = 0;
            load_addr = 0;
         end else if (col_end) begin
            column = 0;
            row    = (row + 1) % (1 << POS_W);
         end else begin
            column = (column + 1) % (1 << POS_W);
         end
      endfunction

      function void compare_field(string field, logic [CHAN_W-1:0] want,
                                  logic [CHAN_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // compare one accepted result item with the oldest pixel due
      function void check_pixel(out_pixel_type got);
         out_pixel_type want;
         if (pixels_due.size() == 0) begin
            $display("%0t: result item with none due, actual %0h %0h %0h last %0b",
                     $time, got.red, got.green, got.blue, got.last);
            mismatches++;
            return;
         end
         want = pixels_due.pop_front();
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("frame_last", CHAN_W'(want.last), CHAN_W'(got.last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_opcode = KIND_LOAD;
   logic [CHAN_W-1:0]     req_in_red = '0;
   logic [CHAN_W-1:0]     req_in_green = '0;
   logic [CHAN_W-1:0]     req_in_blue = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [CHAN_W-1:0]     rsp_out_red;
   logic [CHAN_W-1:0]     rsp_out_green;
   logic [CHAN_W-1:0]     rsp_out_blue;
   logic                  rsp_frame_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SRC_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   raster_tracker raster = new();
   bit            hold_results = 1'b0;
   int unsigned   cycles = 0;

   nearest_neighbor_image_scaler uut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // gap length: mostly none or short, a few long
   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // size register value, now and then zero, and the large extremes when wide
   function automatic logic [SIZE_W-1:0] random_size(int unsigned top, bit wide);
      case ($urandom_range(19))
         0: return '0;
         1: return wide ? SIZE_W'(SIZE_MAX) : SIZE_W'(top);
         2: return wide ? '1 : SIZE_W'(top);
         default: return SIZE_W'($urandom_range(top, 1));
      endcase
   endfunction

   // offer one item and wait until the block takes it
   task automatic send_item(input kind_type kind, input logic [CHAN_W-1:0] red,
                            input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
      req_push     <= 1'b1;
      req_opcode   <= kind;
      req_in_red   <= red;
      req_in_green <= green;
      req_in_blue  <= blue;
      @(posedge clock);
      while (req_full) @(posedge clock);
      raster.note_item(kind, red, green, blue);
   endtask

   task automatic send_random(input kind_type kind);
      send_item(kind, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
   endtask

   task automatic idle_sender(input int unsigned gap);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_size(input csr_index_type idx, input logic [SIZE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      raster.set_size(idx, value);
   endtask

   task automatic set_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                            input logic [SIZE_W-1:0] dw, input logic [SIZE_W-1:0] dh);
      write_size(CSR_SRC_WIDTH, sw);
      write_size(CSR_SRC_HEIGHT, sh);
      write_size(CSR_DST_WIDTH, dw);
      write_size(CSR_DST_HEIGHT, dh);
      csr_we <= 1'b0;
   endtask

   // wait for every pixel due, then let queued loads drain
   task automatic wait_idle();
      req_push <= 1'b0;
      while (raster.pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: random pops, one long hold-off when asked
   initial begin : result_side
      int unsigned gap;
      bit          steady;
      bit          hold_done;
      steady    = 1'b0;
      hold_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(63) == 0) steady = !steady;
         if (hold_results && !hold_done) begin
            gap       = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            gap = pick_gap(steady);
         end
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty) begin
            raster.check_pixel({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_last});
         end
      end
   end

   // stimulus
   initial begin : stimulus
      kind_type    kind;
      int unsigned need;
      bit          steady;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // 2x2 source up to 3x3, pixel extremes, one whole frame
      set_sizes(SIZE_W'(2), SIZE_W'(2), SIZE_W'(3), SIZE_W'(3));
      send_item(KIND_LOAD, 8'h00, 8'h00, 8'h00);
      send_item(KIND_LOAD, 8'hFF, 8'hFF, 8'hFF);
      send_item(KIND_LOAD, 8'hAA, 8'h55, 8'hAA);
      send_item(KIND_LOAD, 8'h55, 8'hAA, 8'h55);
      repeat (9) send_random(KIND_EMIT);
      wait_idle();

      // zero registers act as one, all-ones registers act as the limit
      set_sizes('0, '1, '0, '1);
      repeat (3) send_random(KIND_EMIT);
      wait_idle();

      // registers shrink mid-frame: row lies past the last row
      set_sizes(SIZE_W'(2), SIZE_W'(2), SIZE_W'(3), SIZE_W'(2));
      repeat (3) send_random(KIND_EMIT);
      wait_idle();

      // fill the first entries that the random phases can reach, close the frame
      set_sizes(SIZE_W'(8), SIZE_W'(8), SIZE_W'(1), SIZE_W'(1));
      repeat (SOURCE_CAP) send_random(KIND_LOAD);
      send_random(KIND_EMIT);
      wait_idle();

      // column past the frame: source column saturates at the last column
      set_sizes(SIZE_W'(2), SIZE_W'(1), SIZE_W'(4), SIZE_W'(1));
      repeat (2) send_random(KIND_EMIT);
      wait_idle();
      set_sizes(SIZE_W'(2), SIZE_W'(1), SIZE_W'(1), SIZE_W'(1));
      send_random(KIND_EMIT);
      wait_idle();

      // second row maps beyond the store and reads as zero
      set_sizes(SIZE_W'(SIZE_MAX), SIZE_W'(SIZE_MAX), SIZE_W'(1), SIZE_W'(2));
      repeat (2) send_random(KIND_EMIT);
      wait_idle();

      // random phases: mostly load a source then emit, some noise
      hold_results = 1'b1;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_sizes(random_size(8, 1'b0), random_size(8, 1'b0),
                   random_size(10, 1'b1), random_size(10, 1'b1));
         steady = ($urandom_range(3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            need = raster.size_of(CSR_SRC_WIDTH) * raster.size_of(CSR_SRC_HEIGHT);
            if (need > SOURCE_CAP) need = SOURCE_CAP;
            if ($urandom_range(99) < 85) begin
               if (raster.load_addr < need && raster.column == 0 && raster.row == 0) begin
                  kind = KIND_LOAD;
               end else begin
                  kind = KIND_EMIT;
               end
            end else begin
               kind = kind_type'($urandom_range(1));
            end
            send_random(kind);
            idle_sender(pick_gap(steady));
         end
         wait_idle();
      end

      if (raster.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule : tb
